FILE: rtl/core/ccrj_pkg.sv
package ccrj_pkg;

    // register indexes on the config port
    localparam logic [2:0] REG_WIDTH_SCALE  = 3'd0;
    localparam logic [2:0] REG_CENTER       = 3'd1;
    localparam logic [2:0] REG_SPREAD       = 3'd2;
    localparam logic [2:0] REG_CUBIC_COEF   = 3'd3;
    localparam logic [2:0] REG_QUARTIC_COEF = 3'd4;

    localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] Q_MIN = 32'sh80000000;

    function automatic logic signed [31:0] sat35(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sd2147483647)
            r = Q_MAX;
        else if (v < -35'sd2147483648)
            r = Q_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return sat35(35'(a) + 35'(b));
    endfunction

    function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return sat35(35'(a) - 35'(b));
    endfunction

    function automatic logic signed [31:0] qneg(input logic signed [31:0] a);
        return sat35(35'sd0 - 35'(a));
    endfunction

    function automatic logic signed [31:0] qscale(input logic signed [31:0] a,
                                                  input logic [2:0] k);
        return sat35(35'(a) * $signed({1'b0, k}));
    endfunction

    function automatic logic signed [63:0] mul64(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        return 64'(a) * 64'(b);
    endfunction

    // round to nearest, ties up, then clamp
    function automatic logic signed [31:0] qrnd(input logic signed [63:0] p,
                                                input int frac);
        logic signed [64:0] t;
        logic signed [64:0] q;
        logic signed [31:0] r;
        t = 65'(p) + (65'sd1 <<< (frac - 1));
        q = t >>> frac;
        if (q > 65'sd2147483647)
            r = Q_MAX;
        else if (q < -65'sd2147483648)
            r = Q_MIN;
        else
            r = q[31:0];
        return r;
    endfunction

endpackage

FILE: rtl/core/ccrj_div.sv
// Pipelined fixed-point divider, one quotient bit per stage, shared divisor.
module ccrj_div #(
    parameter int FRAC_BITS = 16,
    parameter int LANES     = 1,
    parameter int TAG_W     = 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [LANES-1:0][31:0]  num,
    input  logic signed [31:0]      den,
    input  logic [TAG_W-1:0]        tag,
    output logic                    out_valid,
    output logic [LANES-1:0][31:0]  quo,
    output logic                    zero,
    output logic [TAG_W-1:0]        tag_out
);

    localparam int NW = 32 + FRAC_BITS;
    localparam int QB = 32;
    localparam int CW = ((NW > QB + 31) ? NW : (QB + 31)) + 1;

    typedef struct packed {
        logic [NW-1:0] rem;
        logic [QB-1:0] q;
        logic          neg;
        logic          ovf;
    } lane_t;

    lane_t           lane_reg [0:QB][LANES];
    logic [31:0]     ud_reg   [0:QB];
    logic            zero_reg [0:QB];
    logic [TAG_W-1:0] tag_reg [0:QB];
    logic            vld_reg  [0:QB];

    lane_t           lane0_next [LANES];
    logic [32:0]     dx;
    logic [31:0]     ud0;

    assign dx  = 33'(den);
    assign ud0 = dx[32] ? 32'(33'd0 - dx) : dx[31:0];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            logic [32:0]   nx;
            logic [32:0]   un;
            logic [NW-1:0] nn;
            nx = 33'($signed(num[l]));
            un = nx[32] ? (33'd0 - nx) : nx;
            nn = (NW'(un) << FRAC_BITS) + NW'(ud0 >> 1);
            lane0_next[l].rem = nn;
            lane0_next[l].q   = '0;
            lane0_next[l].neg = nx[32] ^ dx[32];
            lane0_next[l].ovf = NW'(nn >> QB) >= NW'(ud0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg[0] <= lane0_next;
            ud_reg[0]   <= ud0;
            zero_reg[0] <= (den == 32'sd0);
            tag_reg[0]  <= tag;
        end
    end

    for (genvar k = 1; k <= QB; k++)
    begin : g_stage
        localparam int BI = QB - k;
        logic [CW-1:0] dv;
        lane_t         nxt [LANES];

        assign dv = CW'(ud_reg[k-1]) << BI;

        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                nxt[l] = lane_reg[k-1][l];
                if (CW'(lane_reg[k-1][l].rem) >= dv)
                begin
                    nxt[l].rem   = NW'(CW'(lane_reg[k-1][l].rem) - dv);
                    nxt[l].q[BI] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lane_reg[k] <= nxt;
                ud_reg[k]   <= ud_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
                tag_reg[k]  <= tag_reg[k-1];
            end
        end
    end

    logic [LANES-1:0][31:0] quo_next;
    logic [LANES-1:0][31:0] quo_reg;
    logic                   out_vld_reg;
    logic                   zero_out_reg;
    logic [TAG_W-1:0]       tag_out_reg;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            logic [QB-1:0] q;
            q = lane_reg[QB][l].q;
            if (zero_reg[QB])
                quo_next[l] = '0;
            else if (lane_reg[QB][l].neg)
                quo_next[l] = (lane_reg[QB][l].ovf || q[QB-1]) ? ccrj_pkg::Q_MIN
                                                                : (32'd0 - q);
            else
                quo_next[l] = (lane_reg[QB][l].ovf || q[QB-1]) ? ccrj_pkg::Q_MAX : q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= vld_reg[QB];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg      <= quo_next;
            zero_out_reg <= zero_reg[QB];
            tag_out_reg  <= tag_reg[QB];
        end
    end

    assign out_valid = out_vld_reg;
    assign quo       = quo_reg;
    assign zero      = zero_out_reg;
    assign tag_out   = tag_out_reg;

endmodule

FILE: rtl/core/ccrj_sqrt.sv
// Pipelined floor square root of arg << FRAC_BITS, one result bit per stage.
module ccrj_sqrt #(
    parameter int FRAC_BITS = 16,
    parameter int TAG_W     = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [31:0] arg,
    input  logic [TAG_W-1:0]   tag,
    output logic               out_valid,
    output logic signed [31:0] root,
    output logic               neg,
    output logic [TAG_W-1:0]   tag_out
);

    localparam int SW = 2 * ((33 + FRAC_BITS) / 2);
    localparam int IT = SW / 2;

    logic [SW-1:0]    op_reg  [0:IT];
    logic [SW-1:0]    res_reg [0:IT];
    logic             neg_reg [0:IT];
    logic [TAG_W-1:0] tag_reg [0:IT];
    logic             vld_reg [0:IT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_reg[0]  <= arg[31] ? '0 : (SW'(unsigned'(arg)) << FRAC_BITS);
            res_reg[0] <= '0;
            neg_reg[0] <= arg[31];
            tag_reg[0] <= tag;
        end
    end

    for (genvar k = 1; k <= IT; k++)
    begin : g_iter
        localparam int BP = SW - 2 * k;
        logic [SW:0]   trial;
        logic [SW-1:0] op_next;
        logic [SW-1:0] res_next;

        assign trial = (SW + 1)'(res_reg[k-1]) + ((SW + 1)'(1) << BP);

        always_comb
        begin
            if ((SW + 1)'(op_reg[k-1]) >= trial)
            begin
                op_next  = SW'((SW + 1)'(op_reg[k-1]) - trial);
                res_next = (res_reg[k-1] >> 1) + (SW'(1) << BP);
            end
            else
            begin
                op_next  = op_reg[k-1];
                res_next = res_reg[k-1] >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                op_reg[k]  <= op_next;
                res_reg[k] <= res_next;
                neg_reg[k] <= neg_reg[k-1];
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[IT];
    assign root      = res_reg[IT][31:0];
    assign neg       = neg_reg[IT];
    assign tag_out   = tag_reg[IT];

endmodule

FILE: rtl/core/calib_curve_residual_jacobian.sv
// Curve point evaluator: residual and five partials, all over err, Q-format fixed point.
// Request to result: four 34-stage dividers in series plus the one-bit-per-stage root,
//   with Q16.16 as the default format.
// Throughput: one request per cycle; the whole pipe holds while a result waits.
// Reset (rst_n low, async): all valid bits clear, registers return to w0 = 1.0,
//   c = 0, d = 1.0, A = 0, B = 0.
module calib_curve_residual_jacobian #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] position,
    input  logic signed [31:0] measured,
    input  logic signed [31:0] error_scale,
    input  logic               last_point,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] residual,
    output logic signed [31:0] deriv_amplitude,
    output logic signed [31:0] deriv_center,
    output logic signed [31:0] deriv_spread,
    output logic signed [31:0] deriv_cubic,
    output logic signed [31:0] deriv_quartic,
    output logic               invalid,
    output logic               last_out
);

    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] TWO = ONE <<< 1;

    // ---------------------------------------------------------------
    // Model registers. The user must write them only while the pipe is
    // empty (not enforced here), so every stage reads them directly.
    // ---------------------------------------------------------------
    logic signed [31:0] w0_reg, c_reg, d_reg, a_reg, b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w0_reg <= ONE;
            c_reg  <= 32'sd0;
            d_reg  <= ONE;
            a_reg  <= 32'sd0;
            b_reg  <= 32'sd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ccrj_pkg::REG_WIDTH_SCALE:  w0_reg <= cfg_data;
                ccrj_pkg::REG_CENTER:       c_reg  <= cfg_data;
                ccrj_pkg::REG_SPREAD:       d_reg  <= cfg_data;
                ccrj_pkg::REG_CUBIC_COEF:   a_reg  <= cfg_data;
                ccrj_pkg::REG_QUARTIC_COEF: b_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Stage records. "side" rides the pipe up to the final divider bank, which keeps only last and bad.
    // ---------------------------------------------------------------
    typedef struct packed {
        logic signed [31:0] meas;
        logic signed [31:0] err;
        logic               last;
        logic               bad;
    } side_t;

    typedef struct packed { side_t side; logic signed [31:0] diff; } st0_t;
    typedef struct packed {
        side_t side; logic signed [31:0] u;
        logic signed [63:0] p_uu; logic signed [63:0] p_au; logic signed [63:0] p_3au;
    } st1_t;
    typedef struct packed {
        side_t side; logic signed [31:0] u; logic signed [31:0] u2;
        logic signed [31:0] ta; logic signed [31:0] t3a;
    } st2_t;
    typedef struct packed {
        side_t side; logic signed [31:0] u; logic signed [31:0] u2;
        logic signed [31:0] ta; logic signed [31:0] t3a;
        logic signed [63:0] p_u3; logic signed [63:0] p_u4;
        logic signed [63:0] p_bu2; logic signed [63:0] p_4bu2;
    } st3_t;
    typedef struct packed {
        side_t side; logic signed [31:0] u; logic signed [31:0] u2;
        logic signed [31:0] u3; logic signed [31:0] u4;
        logic signed [31:0] inner; logic signed [31:0] dsq;
    } st4_t;
    typedef struct packed {
        side_t side; logic signed [31:0] u; logic signed [31:0] u3;
        logic signed [31:0] u4; logic signed [31:0] dsq; logic signed [63:0] p_arg;
    } st5_t;
    typedef struct packed {
        side_t side; logic signed [31:0] u; logic signed [31:0] u3;
        logic signed [31:0] u4; logic signed [31:0] dsq;
    } sq_tag_t;
    typedef struct packed { sq_tag_t t; logic signed [31:0] arg; } st6_t;
    typedef struct packed {
        sq_tag_t t; logic signed [31:0] s;
        logic signed [63:0] p_f; logic signed [63:0] p_ww;
    } st7_t;
    typedef struct packed {
        sq_tag_t t; logic signed [31:0] s; logic signed [31:0] resn;
    } fac_tag_t;
    typedef struct packed {
        fac_tag_t t; logic signed [31:0] f2; logic signed [31:0] ww;
    } st8_t;
    typedef struct packed { fac_tag_t t; logic signed [31:0] fac; } g_tag_t;
    typedef struct packed {
        side_t side; logic signed [31:0] u; logic signed [31:0] dsq;
        logic signed [31:0] s; logic signed [31:0] resn;
        logic signed [63:0] p_gu; logic signed [63:0] p_fu3; logic signed [63:0] p_fu4;
    } st10_t;
    typedef struct packed {
        side_t side; logic signed [31:0] u; logic signed [31:0] dsq;
        logic signed [31:0] s; logic signed [31:0] resn; logic signed [31:0] gu;
        logic signed [31:0] n4; logic signed [31:0] n5;
    } st11_t;
    typedef struct packed {
        side_t side; logic signed [31:0] dsq; logic signed [31:0] s;
        logic signed [31:0] resn; logic signed [31:0] n4; logic signed [31:0] n5;
        logic signed [63:0] p_c; logic signed [63:0] p_guu;
    } st12_t;
    typedef struct packed {
        side_t side; logic signed [31:0] dsq; logic signed [31:0] s;
        logic signed [31:0] resn; logic signed [31:0] n4; logic signed [31:0] n5;
        logic signed [31:0] n2; logic signed [31:0] guu;
    } st13_t;
    typedef struct packed {
        side_t side; logic signed [31:0] s; logic signed [31:0] resn;
        logic signed [31:0] n4; logic signed [31:0] n5; logic signed [31:0] n2;
        logic signed [63:0] p_sp;
    } st14_t;
    typedef struct packed {
        side_t side; logic signed [31:0] s; logic signed [31:0] resn;
        logic signed [31:0] n2; logic signed [31:0] n3;
        logic signed [31:0] n4; logic signed [31:0] n5;
    } st15_t;
    typedef struct packed { logic last; logic bad; } fin_tag_t;

    // Global advance: everything moves unless a finished result is stuck.
    logic en;
    logic out_vld_reg;

    assign en       = !out_vld_reg || out_ready;
    assign in_ready = en;

    // ---------------------------------------------------------------
    // Stage 0: capture request, offset from center.
    // ---------------------------------------------------------------
    logic s0_vld_reg;
    st0_t s0_reg, s0_next;

    always_comb
    begin
        s0_next.side.meas = measured;
        s0_next.side.err  = error_scale;
        s0_next.side.last = last_point;
        s0_next.side.bad  = 1'b0;
        s0_next.diff      = ccrj_pkg::qsub(position, c_reg);
    end

    // u = (x - c) / d
    logic                du_vld;
    logic [0:0][31:0]    du_quo;
    logic                du_zero;
    side_t               du_tag;

    ccrj_div #(.FRAC_BITS(FRAC_BITS), .LANES(1), .TAG_W($bits(side_t))) u_div_u (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(s0_vld_reg), .num(s0_reg.diff), .den(d_reg), .tag(s0_reg.side),
        .out_valid(du_vld), .quo(du_quo), .zero(du_zero), .tag_out(du_tag)
    );

    // ---------------------------------------------------------------
    // Stages 1-6: polynomial in u and the root argument.
    // ---------------------------------------------------------------
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg, s6_vld_reg;
    st1_t s1_reg, s1_next;
    st2_t s2_reg, s2_next;
    st3_t s3_reg, s3_next;
    st4_t s4_reg, s4_next;
    st5_t s5_reg, s5_next;
    st6_t s6_reg, s6_next;

    always_comb
    begin
        logic signed [31:0] u;
        u = du_quo[0];
        s1_next.side     = du_tag;
        s1_next.side.bad = du_tag.bad | du_zero;
        s1_next.u        = u;
        s1_next.p_uu     = ccrj_pkg::mul64(u, u);
        s1_next.p_au     = ccrj_pkg::mul64(a_reg, u);
        s1_next.p_3au    = ccrj_pkg::mul64(ccrj_pkg::qscale(a_reg, 3'd3), u);
    end

    always_comb
    begin
        s2_next.side = s1_reg.side;
        s2_next.u    = s1_reg.u;
        s2_next.u2   = ccrj_pkg::qrnd(s1_reg.p_uu, FRAC_BITS);
        s2_next.ta   = ccrj_pkg::qrnd(s1_reg.p_au, FRAC_BITS);
        s2_next.t3a  = ccrj_pkg::qrnd(s1_reg.p_3au, FRAC_BITS);
    end

    always_comb
    begin
        s3_next.side   = s2_reg.side;
        s3_next.u      = s2_reg.u;
        s3_next.u2     = s2_reg.u2;
        s3_next.ta     = s2_reg.ta;
        s3_next.t3a    = s2_reg.t3a;
        s3_next.p_u3   = ccrj_pkg::mul64(s2_reg.u2, s2_reg.u);
        s3_next.p_u4   = ccrj_pkg::mul64(s2_reg.u2, s2_reg.u2);
        s3_next.p_bu2  = ccrj_pkg::mul64(b_reg, s2_reg.u2);
        s3_next.p_4bu2 = ccrj_pkg::mul64(ccrj_pkg::qscale(b_reg, 3'd4), s2_reg.u2);
    end

    always_comb
    begin
        s4_next.side  = s3_reg.side;
        s4_next.u     = s3_reg.u;
        s4_next.u2    = s3_reg.u2;
        s4_next.u3    = ccrj_pkg::qrnd(s3_reg.p_u3, FRAC_BITS);
        s4_next.u4    = ccrj_pkg::qrnd(s3_reg.p_u4, FRAC_BITS);
        // inner = 1 + A u + B u^2 ; dsq = 2 + 3A u + 4B u^2
        s4_next.inner = ccrj_pkg::qadd(ccrj_pkg::qadd(ONE, s3_reg.ta),
                                       ccrj_pkg::qrnd(s3_reg.p_bu2, FRAC_BITS));
        s4_next.dsq   = ccrj_pkg::qadd(ccrj_pkg::qadd(TWO, s3_reg.t3a),
                                       ccrj_pkg::qrnd(s3_reg.p_4bu2, FRAC_BITS));
    end

    always_comb
    begin
        s5_next.side  = s4_reg.side;
        s5_next.u     = s4_reg.u;
        s5_next.u3    = s4_reg.u3;
        s5_next.u4    = s4_reg.u4;
        s5_next.dsq   = s4_reg.dsq;
        s5_next.p_arg = ccrj_pkg::mul64(s4_reg.u2, s4_reg.inner);
    end

    always_comb
    begin
        s6_next.t.side = s5_reg.side;
        s6_next.t.u    = s5_reg.u;
        s6_next.t.u3   = s5_reg.u3;
        s6_next.t.u4   = s5_reg.u4;
        s6_next.t.dsq  = s5_reg.dsq;
        s6_next.arg    = ccrj_pkg::qadd(ONE, ccrj_pkg::qrnd(s5_reg.p_arg, FRAC_BITS));
    end

    // s = sqrt(arg); negative argument flags the point
    logic               sq_vld;
    logic signed [31:0] sq_root;
    logic               sq_neg;
    sq_tag_t            sq_tag;

    ccrj_sqrt #(.FRAC_BITS(FRAC_BITS), .TAG_W($bits(sq_tag_t))) u_sqrt (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(s6_vld_reg), .arg(s6_reg.arg), .tag(s6_reg.t),
        .out_valid(sq_vld), .root(sq_root), .neg(sq_neg), .tag_out(sq_tag)
    );

    // ---------------------------------------------------------------
    // Stages 7-8: model value f, residual numerator, 2f and w0^2.
    // ---------------------------------------------------------------
    logic s7_vld_reg, s8_vld_reg;
    st7_t s7_reg, s7_next;
    st8_t s8_reg, s8_next;

    always_comb
    begin
        s7_next.t          = sq_tag;
        s7_next.t.side.bad = sq_tag.side.bad | sq_neg;
        s7_next.s          = sq_root;
        s7_next.p_f        = ccrj_pkg::mul64(w0_reg, sq_root);
        s7_next.p_ww       = ccrj_pkg::mul64(w0_reg, w0_reg);
    end

    always_comb
    begin
        logic signed [31:0] f;
        f = ccrj_pkg::qrnd(s7_reg.p_f, FRAC_BITS);
        s8_next.t.t    = s7_reg.t;
        s8_next.t.s    = s7_reg.s;
        s8_next.t.resn = ccrj_pkg::qsub(f, s7_reg.t.side.meas);
        s8_next.f2     = ccrj_pkg::qscale(f, 3'd2);
        s8_next.ww     = ccrj_pkg::qrnd(s7_reg.p_ww, FRAC_BITS);
    end

    // fac = w0^2 / (2f)
    logic             df_vld;
    logic [0:0][31:0] df_quo;
    logic             df_zero;
    fac_tag_t         df_tag;

    ccrj_div #(.FRAC_BITS(FRAC_BITS), .LANES(1), .TAG_W($bits(fac_tag_t))) u_div_fac (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(s8_vld_reg), .num(s8_reg.ww), .den(s8_reg.f2), .tag(s8_reg.t),
        .out_valid(df_vld), .quo(df_quo), .zero(df_zero), .tag_out(df_tag)
    );

    // g = fac / d
    g_tag_t dg_in;
    always_comb
    begin
        dg_in.t            = df_tag;
        dg_in.t.t.side.bad = df_tag.t.side.bad | df_zero;
        dg_in.fac          = df_quo[0];
    end

    logic             dg_vld;
    logic [0:0][31:0] dg_quo;
    logic             dg_zero;
    g_tag_t           dg_tag;

    ccrj_div #(.FRAC_BITS(FRAC_BITS), .LANES(1), .TAG_W($bits(g_tag_t))) u_div_g (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(df_vld), .num(dg_in.fac), .den(d_reg), .tag(dg_in),
        .out_valid(dg_vld), .quo(dg_quo), .zero(dg_zero), .tag_out(dg_tag)
    );

    // ---------------------------------------------------------------
    // Stages 10-15: derivative numerators.
    // ---------------------------------------------------------------
    logic  s10_vld_reg, s11_vld_reg, s12_vld_reg, s13_vld_reg, s14_vld_reg, s15_vld_reg;
    st10_t s10_reg, s10_next;
    st11_t s11_reg, s11_next;
    st12_t s12_reg, s12_next;
    st13_t s13_reg, s13_next;
    st14_t s14_reg, s14_next;
    st15_t s15_reg, s15_next;

    always_comb
    begin
        logic signed [31:0] g;
        g = dg_quo[0];
        s10_next.side     = dg_tag.t.t.side;
        s10_next.side.bad = dg_tag.t.t.side.bad | dg_zero;
        s10_next.u        = dg_tag.t.t.u;
        s10_next.dsq      = dg_tag.t.t.dsq;
        s10_next.s        = dg_tag.t.s;
        s10_next.resn     = dg_tag.t.resn;
        s10_next.p_gu     = ccrj_pkg::mul64(g, dg_tag.t.t.u);
        s10_next.p_fu3    = ccrj_pkg::mul64(dg_tag.fac, dg_tag.t.t.u3);
        s10_next.p_fu4    = ccrj_pkg::mul64(dg_tag.fac, dg_tag.t.t.u4);
    end

    always_comb
    begin
        s11_next.side = s10_reg.side;
        s11_next.u    = s10_reg.u;
        s11_next.dsq  = s10_reg.dsq;
        s11_next.s    = s10_reg.s;
        s11_next.resn = s10_reg.resn;
        s11_next.gu   = ccrj_pkg::qrnd(s10_reg.p_gu, FRAC_BITS);
        s11_next.n4   = ccrj_pkg::qrnd(s10_reg.p_fu3, FRAC_BITS);
        s11_next.n5   = ccrj_pkg::qrnd(s10_reg.p_fu4, FRAC_BITS);
    end

    always_comb
    begin
        s12_next.side  = s11_reg.side;
        s12_next.dsq   = s11_reg.dsq;
        s12_next.s     = s11_reg.s;
        s12_next.resn  = s11_reg.resn;
        s12_next.n4    = s11_reg.n4;
        s12_next.n5    = s11_reg.n5;
        s12_next.p_c   = ccrj_pkg::mul64(s11_reg.gu, s11_reg.dsq);
        s12_next.p_guu = ccrj_pkg::mul64(s11_reg.gu, s11_reg.u);
    end

    always_comb
    begin
        s13_next.side = s12_reg.side;
        s13_next.dsq  = s12_reg.dsq;
        s13_next.s    = s12_reg.s;
        s13_next.resn = s12_reg.resn;
        s13_next.n4   = s12_reg.n4;
        s13_next.n5   = s12_reg.n5;
        s13_next.n2   = ccrj_pkg::qneg(ccrj_pkg::qrnd(s12_reg.p_c, FRAC_BITS));
        s13_next.guu  = ccrj_pkg::qrnd(s12_reg.p_guu, FRAC_BITS);
    end

    always_comb
    begin
        s14_next.side = s13_reg.side;
        s14_next.s    = s13_reg.s;
        s14_next.resn = s13_reg.resn;
        s14_next.n4   = s13_reg.n4;
        s14_next.n5   = s13_reg.n5;
        s14_next.n2   = s13_reg.n2;
        s14_next.p_sp = ccrj_pkg::mul64(s13_reg.guu, s13_reg.dsq);
    end

    always_comb
    begin
        s15_next.side = s14_reg.side;
        s15_next.s    = s14_reg.s;
        s15_next.resn = s14_reg.resn;
        s15_next.n2   = s14_reg.n2;
        s15_next.n3   = ccrj_pkg::qneg(ccrj_pkg::qrnd(s14_reg.p_sp, FRAC_BITS));
        s15_next.n4   = s14_reg.n4;
        s15_next.n5   = s14_reg.n5;
    end

    // six numerators over err in one divider bank
    logic [5:0][31:0] fin_num;
    fin_tag_t         fin_in_tag;
    logic             fin_vld;
    logic [5:0][31:0] fin_quo;
    logic             fin_zero;
    fin_tag_t         fin_tag;

    assign fin_num[0]      = s15_reg.resn;
    assign fin_num[1]      = s15_reg.s;
    assign fin_num[2]      = s15_reg.n2;
    assign fin_num[3]      = s15_reg.n3;
    assign fin_num[4]      = s15_reg.n4;
    assign fin_num[5]      = s15_reg.n5;
    assign fin_in_tag.last = s15_reg.side.last;
    assign fin_in_tag.bad  = s15_reg.side.bad;

    ccrj_div #(.FRAC_BITS(FRAC_BITS), .LANES(6), .TAG_W($bits(fin_tag_t))) u_div_err (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(s15_vld_reg), .num(fin_num), .den(s15_reg.side.err), .tag(fin_in_tag),
        .out_valid(fin_vld), .quo(fin_quo), .zero(fin_zero), .tag_out(fin_tag)
    );

    // ---------------------------------------------------------------
    // Valid bits and stage registers.
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg  <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            s6_vld_reg  <= 1'b0;
            s7_vld_reg  <= 1'b0;
            s8_vld_reg  <= 1'b0;
            s10_vld_reg <= 1'b0;
            s11_vld_reg <= 1'b0;
            s12_vld_reg <= 1'b0;
            s13_vld_reg <= 1'b0;
            s14_vld_reg <= 1'b0;
            s15_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_vld_reg  <= in_valid;
            s1_vld_reg  <= du_vld;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= s3_vld_reg;
            s5_vld_reg  <= s4_vld_reg;
            s6_vld_reg  <= s5_vld_reg;
            s7_vld_reg  <= sq_vld;
            s8_vld_reg  <= s7_vld_reg;
            s10_vld_reg <= dg_vld;
            s11_vld_reg <= s10_vld_reg;
            s12_vld_reg <= s11_vld_reg;
            s13_vld_reg <= s12_vld_reg;
            s14_vld_reg <= s13_vld_reg;
            s15_vld_reg <= s14_vld_reg;
            out_vld_reg <= fin_vld;
        end
    end

    logic               bad_fin;
    logic [5:0][31:0]   res_reg;
    logic               invalid_reg;
    logic               last_reg;

    assign bad_fin = fin_tag.bad | fin_zero;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_reg  <= s0_next;
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            s3_reg  <= s3_next;
            s4_reg  <= s4_next;
            s5_reg  <= s5_next;
            s6_reg  <= s6_next;
            s7_reg  <= s7_next;
            s8_reg  <= s8_next;
            s10_reg <= s10_next;
            s11_reg <= s11_next;
            s12_reg <= s12_next;
            s13_reg <= s13_next;
            s14_reg <= s14_next;
            s15_reg <= s15_next;
            // a flagged point reports zeros in every result field
            res_reg     <= bad_fin ? '0 : fin_quo;
            invalid_reg <= bad_fin;
            last_reg    <= fin_tag.last;
        end
    end

    assign out_valid       = out_vld_reg;
    assign residual        = res_reg[0];
    assign deriv_amplitude = res_reg[1];
    assign deriv_center    = res_reg[2];
    assign deriv_spread    = res_reg[3];
    assign deriv_cubic     = res_reg[4];
    assign deriv_quartic   = res_reg[5];
    assign invalid         = invalid_reg;
    assign last_out        = last_reg;

endmodule

FILE: rtl/core/ccrj_checker.sv
module ccrj_props (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] residual,
    input logic signed [31:0] deriv_amplitude,
    input logic signed [31:0] deriv_center,
    input logic signed [31:0] deriv_spread,
    input logic signed [31:0] deriv_cubic,
    input logic signed [31:0] deriv_quartic,
    input logic               invalid,
    input logic               last_out
);

    // flagged result carries all-zero fields
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && invalid |-> residual == 32'sd0 && deriv_amplitude == 32'sd0 &&
            deriv_center == 32'sd0 && deriv_spread == 32'sd0 &&
            deriv_cubic == 32'sd0 && deriv_quartic == 32'sd0)
        else $error("flagged result has nonzero fields");

    // input side only stalls while a result is held
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready not tied to output stall");

    // nothing can come out right after reset
    a_reset: assert property (@(posedge clk)
        !$past(rst_n) |-> !out_valid)
        else $error("result right after reset");

    // held result keeps its residual, invalid and last_out
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(residual) &&
            $stable(invalid) && $stable(last_out))
        else $error("held result changed");

endmodule

bind calib_curve_residual_jacobian ccrj_props u_ccrj_props (.*);

FILE: bench/ccrj_checker.sv
`timescale 1ns / 1ps

module ccrj_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [31:0] position,
    input  logic signed [31:0] measured,
    input  logic signed [31:0] error_scale,
    input  logic               last_point,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] residual,
    input  logic signed [31:0] deriv_amplitude,
    input  logic signed [31:0] deriv_center,
    input  logic signed [31:0] deriv_spread,
    input  logic signed [31:0] deriv_cubic,
    input  logic signed [31:0] deriv_quartic,
    input  logic               invalid,
    input  logic               last_out,
    output int                 fail_count,
    output int                 pending
);

    localparam int FB = 16;
    localparam longint ONE_Q = longint'(1) << FB;
    localparam longint MAX32 = 64'sd2147483647;
    localparam longint MIN32 = -64'sd2147483648;

    typedef struct packed {
        logic signed [31:0] res;
        logic signed [31:0] d_amp;
        logic signed [31:0] d_cen;
        logic signed [31:0] d_spr;
        logic signed [31:0] d_cub;
        logic signed [31:0] d_qua;
        logic               inv;
        logic               last;
    } point_result_t;

    point_result_t expected_points[$];

    // shadow copy of the model coefficients
    logic signed [31:0] w0, c0, dd, ca, cb;

    function automatic logic signed [31:0] clamp(input longint v);
        if (v > MAX32)
            return 32'sh7fffffff;
        if (v < MIN32)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // product rounded to nearest, ties up (arithmetic shift is a floor)
    function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        longint t;
        t = longint'(a) * longint'(b) + (longint'(1) << (FB - 1));
        return clamp(t >>> FB);
    endfunction

    // quotient rounded to nearest, ties away from zero; zero divisor gives 0
    function automatic logic signed [31:0] fx_div(input logic signed [31:0] n,
                                                  input logic signed [31:0] d);
        longint unsigned un, ud, q;
        if (d == 0)
            return 0;
        un = (n < 0) ? longint'(-longint'(n)) : longint'(n);
        ud = (d < 0) ? longint'(-longint'(d)) : longint'(d);
        q = ((un << FB) + ud / 2) / ud;
        if ((n < 0) != (d < 0))
        begin
            if (q >= 64'h80000000)
                return 32'sh80000000;
            return 32'(-longint'(q));
        end
        if (q > 64'h7fffffff)
            return 32'sh7fffffff;
        return 32'(q);
    endfunction

    // floor of the root; negative argument gives 0
    function automatic logic signed [31:0] fx_sqrt(input logic signed [31:0] v);
        longint unsigned op, r, b;
        if (v < 0)
            return 0;
        op = longint'(v) << FB;
        r = 0;
        b = longint'(1) << 62;
        while (b > op)
            b = b >> 2;
        while (b != 0)
        begin
            if (op >= r + b)
            begin
                op = op - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return 32'(r);
    endfunction

    function automatic point_result_t eval_point(input logic signed [31:0] x,
                                                 input logic signed [31:0] m,
                                                 input logic signed [31:0] e,
                                                 input logic lp);
        point_result_t p;
        logic signed [31:0] one, u, u2, u3, u4, inner, arg, s, f, f2, fac, dsq, g, gu;
        logic bad;
        one = 32'(ONE_Q);
        bad = (dd == 0) || (e == 0);
        u = fx_div(clamp(longint'(x) - longint'(c0)), dd);
        u2 = fx_mul(u, u);
        u3 = fx_mul(u2, u);
        u4 = fx_mul(u2, u2);
        inner = clamp(longint'(clamp(longint'(one) + longint'(fx_mul(ca, u))))
                      + longint'(fx_mul(cb, u2)));
        arg = clamp(longint'(one) + longint'(fx_mul(u2, inner)));
        bad = bad || (arg < 0);
        s = fx_sqrt(arg);
        f = fx_mul(w0, s);
        f2 = clamp(longint'(f) * 2);
        bad = bad || (f2 == 0);
        fac = fx_div(fx_mul(w0, w0), f2);
        dsq = clamp(longint'(clamp(2 * ONE_Q
                      + longint'(fx_mul(clamp(longint'(ca) * 3), u))))
                    + longint'(fx_mul(clamp(longint'(cb) * 4), u2)));
        g = fx_div(fac, dd);
        gu = fx_mul(g, u);
        p.res = fx_div(clamp(longint'(f) - longint'(m)), e);
        p.d_amp = fx_div(s, e);
        p.d_cen = fx_div(clamp(-longint'(fx_mul(gu, dsq))), e);
        p.d_spr = fx_div(clamp(-longint'(fx_mul(fx_mul(gu, u), dsq))), e);
        p.d_cub = fx_div(fx_mul(fac, u3), e);
        p.d_qua = fx_div(fx_mul(fac, u4), e);
        if (bad)
        begin
            p.res = 0;
            p.d_amp = 0;
            p.d_cen = 0;
            p.d_spr = 0;
            p.d_cub = 0;
            p.d_qua = 0;
        end
        p.inv = bad;
        p.last = lp;
        return p;
    endfunction

    task automatic check_field(input string name, input logic signed [31:0] exp_v,
                               input logic signed [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        point_result_t want;
        if (!rst_n)
        begin
            w0 <= 32'(ONE_Q);
            c0 <= 0;
            dd <= 32'(ONE_Q);
            ca <= 0;
            cb <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ccrj_pkg::REG_WIDTH_SCALE:  w0 <= cfg_data;
                    ccrj_pkg::REG_CENTER:       c0 <= cfg_data;
                    ccrj_pkg::REG_SPREAD:       dd <= cfg_data;
                    ccrj_pkg::REG_CUBIC_COEF:   ca <= cfg_data;
                    ccrj_pkg::REG_QUARTIC_COEF: cb <= cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                expected_points.push_back(eval_point(position, measured, error_scale,
                                                     last_point));
            if (out_valid && out_ready)
            begin
                if (expected_points.size() == 0)
                begin
                    $error("result with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_points.pop_front();
                    check_field("residual", want.res, residual);
                    check_field("deriv_amplitude", want.d_amp, deriv_amplitude);
                    check_field("deriv_center", want.d_cen, deriv_center);
                    check_field("deriv_spread", want.d_spr, deriv_spread);
                    check_field("deriv_cubic", want.d_cub, deriv_cubic);
                    check_field("deriv_quartic", want.d_qua, deriv_quartic);
                    check_field("invalid", 32'(want.inv), 32'(invalid));
                    check_field("last_out", 32'(want.last), 32'(last_out));
                end
            end
        end
        pending = expected_points.size();
    end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam logic signed [31:0] ONE = 32'sh00010000;
    localparam int LAT_CYCLES = 200;      // longer than the pipe
    localparam int LONG_HOLD = 600;       // longer than the pipe, forces input stall
    localparam int CYCLE_LIMIT = 600000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [31:0] position = '0;
    logic signed [31:0] measured = '0;
    logic signed [31:0] error_scale = '0;
    logic               last_point = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] residual, deriv_amplitude, deriv_center, deriv_spread;
    logic signed [31:0] deriv_cubic, deriv_quartic;
    logic               invalid, last_out;

    int  fail_count, pending;
    int  cycles = 0;
    bit  idle_on = 1'b1;      // random gaps on both sides; off near the end
    bit  long_hold = 1'b0;    // request for one long receiver hold-off

    always #2 clk = ~clk;

    calib_curve_residual_jacobian dut (.*);

    ccrj_checker chk (.*);

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                out_ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 16) - 1) @(negedge clk);
            end
            else
                out_ready = 1'b1;
        end
    end

    // register write; only called with the pipe drained
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // assumes we sit at a falling edge; leaves us at one after acceptance
    task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] m,
                              input logic signed [31:0] e, input logic lp);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        position = x;
        measured = m;
        error_scale = e;
        last_point = lp;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // pause the sender until every outstanding request has its result
    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (LAT_CYCLES) @(negedge clk);
    endtask

    // mostly modest Q16.16 values so the math stays in range, some full-range ones
    function automatic logic signed [31:0] pick_q(input int span);
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
            2:       return 0;
            default: return $signed($urandom_range(0, 2 * span)) - span;
        endcase
    endfunction

    task automatic random_points(input int n, input int span);
        logic signed [31:0] e;
        repeat (n)
        begin
            e = pick_q(4 * ONE);
            if (e == 0 && $urandom_range(0, 3) != 0)
                e = ONE;
            send_point(pick_q(span), pick_q(span), e, $urandom_range(0, 7) == 0);
        end
    endtask

    task automatic random_config(input int span);
        logic signed [31:0] d;
        d = $signed($urandom_range(ONE / 4, 4 * ONE));
        write_reg(ccrj_pkg::REG_WIDTH_SCALE, pick_q(span));
        write_reg(ccrj_pkg::REG_CENTER, pick_q(span));
        write_reg(ccrj_pkg::REG_SPREAD, ($urandom_range(0, 1) != 0) ? d : -d);
        write_reg(ccrj_pkg::REG_CUBIC_COEF, $signed($urandom_range(0, 2 * ONE)) - ONE);
        write_reg(ccrj_pkg::REG_QUARTIC_COEF,
                  $signed($urandom_range(0, 2 * ONE)) - ONE / 2);
    endtask

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: reset coefficients, field extremes
        send_point(0, 0, ONE, 1'b0);
        send_point(32'sh7fffffff, 32'sh80000000, ONE, 1'b1);
        send_point(32'sh80000000, 32'sh7fffffff, -ONE, 1'b0);
        send_point(ONE, ONE, 0, 1'b1);                        // zero error scale
        send_point(2 * ONE, -ONE, 32'sh7fffffff, 1'b0);
        send_point(-3 * ONE, 0, 32'sh80000000, 1'b1);
        send_point(ONE / 2, ONE, 1, 1'b0);                    // tiny divisor saturates
        send_point(32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b1);
        drain();

        // negative root argument: A = -1, u = 2 gives arg = -3
        write_reg(ccrj_pkg::REG_CUBIC_COEF, -ONE);
        write_reg(3'd7, 32'hdeadbeef);                        // unknown index, ignored
        send_point(2 * ONE, 0, ONE, 1'b0);
        send_point(-2 * ONE, 0, ONE, 1'b1);
        drain();

        // zero spread
        write_reg(ccrj_pkg::REG_SPREAD, 0);
        send_point(ONE, ONE, ONE, 1'b0);
        send_point(0, 0, ONE, 1'b1);
        drain();

        // zero amplitude makes the model value zero
        write_reg(ccrj_pkg::REG_SPREAD, ONE);
        write_reg(ccrj_pkg::REG_CUBIC_COEF, 0);
        write_reg(ccrj_pkg::REG_WIDTH_SCALE, 0);
        send_point(ONE, ONE, ONE, 1'b0);
        drain();

        // all coefficients at the top, then at the bottom of the range
        write_reg(ccrj_pkg::REG_WIDTH_SCALE, 32'h7fffffff);
        write_reg(ccrj_pkg::REG_CENTER, 32'h7fffffff);
        write_reg(ccrj_pkg::REG_SPREAD, 32'h7fffffff);
        write_reg(ccrj_pkg::REG_CUBIC_COEF, 32'h7fffffff);
        write_reg(ccrj_pkg::REG_QUARTIC_COEF, 32'h7fffffff);
        send_point(0, 0, ONE, 1'b0);
        send_point(32'sh80000000, ONE, -ONE, 1'b1);
        random_points(20, 32'sh7fffffff);
        drain();
        write_reg(ccrj_pkg::REG_WIDTH_SCALE, 32'h80000000);
        write_reg(ccrj_pkg::REG_CENTER, 32'h80000000);
        write_reg(ccrj_pkg::REG_SPREAD, 32'h80000000);
        write_reg(ccrj_pkg::REG_CUBIC_COEF, 32'h80000000);
        write_reg(ccrj_pkg::REG_QUARTIC_COEF, 32'h80000000);
        send_point(32'sh7fffffff, 0, ONE, 1'b0);
        random_points(20, 32'sh7fffffff);
        drain();

        // random coefficient sets with random points
        repeat (6)
        begin
            random_config(4 * ONE);
            random_points(90, 8 * ONE);
            drain();
        end

        // long receiver hold-off while the sender keeps pushing: pipe fills
        random_config(2 * ONE);
        long_hold = 1'b1;
        random_points(300, 4 * ONE);
        drain();

        // last stretch runs back to back with no idling on either side
        idle_on = 1'b0;
        random_config(4 * ONE);
        random_points(150, 8 * ONE);
        drain();

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
